// File: hdl/hsms_pkg.sv
// ----------------------------------------------------------------------------
// hsms_pkg
// types, constants and angle helpers shared by the motion sequencer modules
// ----------------------------------------------------------------------------
package hsms_pkg;

    localparam int unsigned HEADING_IN_W  = 13;
    localparam int unsigned HEADING_W     = 14;
    localparam int unsigned ANGLE_W       = 12;
    localparam int unsigned SPEED_W       = 16;
    localparam int unsigned DIFF_W        = 15;
    localparam int unsigned CFG_ADDR_W    = 4;
    localparam int unsigned CFG_DATA_W    = 32;

    localparam logic signed [DIFF_W-1:0] HALF_TURN = 15'sd2880;
    localparam logic signed [DIFF_W-1:0] FULL_TURN = 15'sd5760;

    localparam logic [ANGLE_W-1:0] TURN_THRESHOLD_RST = 12'd80;
    localparam logic [ANGLE_W-1:0] TURN_STEP_RST      = 12'd16;
    localparam logic [SPEED_W-1:0] ACCEL_STEP_RST     = 16'd64;
    localparam logic [SPEED_W-1:0] MAX_SPEED_RST      = 16'd4096;

    typedef enum logic [2:0] {
        PH_STOPPED = 3'd0,
        PH_ACCEL   = 3'd1,
        PH_MOVING  = 3'd2,
        PH_TURNING = 3'd3,
        PH_DECEL   = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        REG_TURN_THRESHOLD = 2'd0,
        REG_TURN_STEP      = 2'd1,
        REG_ACCEL_STEP     = 2'd2,
        REG_MAX_SPEED      = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [ANGLE_W-1:0] turn_threshold;
        logic [ANGLE_W-1:0] turn_step;
        logic [SPEED_W-1:0] accel_step;
        logic [SPEED_W-1:0] max_speed;
    } t_cfg;

    typedef struct packed {
        t_phase                         phase;
        logic signed [HEADING_W-1:0]    heading_now;
        logic signed [HEADING_IN_W-1:0] heading_goal;
        logic [ANGLE_W-1:0]             turn_left;
        logic [SPEED_W-1:0]             speed;
    } t_state;

    // wrap an angle difference into plus or minus half a turn
    function automatic logic signed [HEADING_IN_W-1:0] wrap_angle(
        input logic signed [DIFF_W-1:0] a
    );
        logic signed [DIFF_W-1:0] v;
        v = a;
        if (v > HALF_TURN) begin
            v = v - FULL_TURN;
        end
        if (v > HALF_TURN) begin
            v = v - FULL_TURN;
        end
        if (v < -HALF_TURN) begin
            v = v + FULL_TURN;
        end
        if (v < -HALF_TURN) begin
            v = v + FULL_TURN;
        end
        return v[HEADING_IN_W-1:0];
    endfunction

    function automatic logic [ANGLE_W-1:0] abs_angle(
        input logic signed [HEADING_IN_W-1:0] d
    );
        logic signed [HEADING_IN_W-1:0] neg;
        neg = -d;
        return d[HEADING_IN_W-1] ? neg[ANGLE_W-1:0] : d[ANGLE_W-1:0];
    endfunction

endpackage

// File: hdl/heading_speed_motion_sequencer_unit.sv
// ----------------------------------------------------------------------------
// heading_speed_motion_sequencer_unit
// an accepted beat waits in the input register and moves to the result register when the output is not stalled
// throughput: one beat per cycle while i_stall stays low; the state update is combinational
// input register and result register part the two sides of the pipe
// reset: synchronous active low; state cleared to stopped, zero speed and
// heading; config registers return to their default values
// ----------------------------------------------------------------------------
module heading_speed_motion_sequencer_unit (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        psel,
    input  logic                                        penable,
    input  logic                                        pwrite,
    input  logic [hsms_pkg::CFG_ADDR_W-1:0]             paddr,
    input  logic [hsms_pkg::CFG_DATA_W-1:0]             pwdata,
    output logic [hsms_pkg::CFG_DATA_W-1:0]             prdata,
    output logic                                        pready,
    input  logic                                        i_valid,
    output logic                                        o_stall,
    input  logic signed [hsms_pkg::HEADING_IN_W-1:0]    i_desired_heading,
    output logic                                        o_valid,
    input  logic                                        i_stall,
    output logic [2:0]                                  o_phase_out,
    output logic [hsms_pkg::SPEED_W-1:0]                o_speed_out,
    output logic signed [hsms_pkg::HEADING_W-1:0]       o_heading_out
);

    hsms_pkg::t_cfg   w_cfg;
    hsms_pkg::t_state r_state;
    hsms_pkg::t_state n_state;

    logic                                      r_in_vld;
    logic signed [hsms_pkg::HEADING_IN_W-1:0]  r_in_heading;
    logic                                      r_out_vld;
    logic [2:0]                                r_phase_out;
    logic [hsms_pkg::SPEED_W-1:0]              r_speed_out;
    logic signed [hsms_pkg::HEADING_W-1:0]     r_heading_out;
    logic                                      w_fire;
    logic                                      w_take;

    hsms_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    hsms_step u_step (
        .i_cfg     (w_cfg),
        .i_cur     (r_state),
        .i_desired (r_in_heading),
        .o_nxt     (n_state)
    );

    assign w_fire  = r_in_vld && (!r_out_vld || !i_stall);
    assign o_stall = r_in_vld && !w_fire;
    assign w_take  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= '0;
        end else begin
            if (w_take) begin
                r_in_vld <= 1'b1;
            end else if (w_fire) begin
                r_in_vld <= 1'b0;
            end
            if (w_fire) begin
                r_out_vld <= 1'b1;
                r_state   <= n_state;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_heading <= i_desired_heading;
        end
        if (w_fire) begin
            r_phase_out   <= n_state.phase;
            r_speed_out   <= n_state.speed;
            r_heading_out <= n_state.heading_now;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_phase_out   = r_phase_out;
    assign o_speed_out   = r_speed_out;
    assign o_heading_out = r_heading_out;

endmodule

// File: hdl/hsms_cfg.sv
// ----------------------------------------------------------------------------
// hsms_cfg
// apb register file holding threshold, turn step, accel step and max speed
// ----------------------------------------------------------------------------
module hsms_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [hsms_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [hsms_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [hsms_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready,
    output hsms_pkg::t_cfg                    o_cfg
);

    hsms_pkg::t_cfg   r_cfg;
    hsms_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign w_idx  = hsms_pkg::t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.turn_threshold <= hsms_pkg::TURN_THRESHOLD_RST;
            r_cfg.turn_step      <= hsms_pkg::TURN_STEP_RST;
            r_cfg.accel_step     <= hsms_pkg::ACCEL_STEP_RST;
            r_cfg.max_speed      <= hsms_pkg::MAX_SPEED_RST;
        end else if (w_wr) begin
            case (w_idx)
                hsms_pkg::REG_TURN_THRESHOLD: begin
                    r_cfg.turn_threshold <= pwdata[hsms_pkg::ANGLE_W-1:0];
                end
                hsms_pkg::REG_TURN_STEP: begin
                    r_cfg.turn_step <= pwdata[hsms_pkg::ANGLE_W-1:0];
                end
                hsms_pkg::REG_ACCEL_STEP: begin
                    r_cfg.accel_step <= pwdata[hsms_pkg::SPEED_W-1:0];
                end
                hsms_pkg::REG_MAX_SPEED: begin
                    r_cfg.max_speed <= pwdata[hsms_pkg::SPEED_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            hsms_pkg::REG_TURN_THRESHOLD: prdata = 32'(r_cfg.turn_threshold);
            hsms_pkg::REG_TURN_STEP:      prdata = 32'(r_cfg.turn_step);
            hsms_pkg::REG_ACCEL_STEP:     prdata = 32'(r_cfg.accel_step);
            hsms_pkg::REG_MAX_SPEED:      prdata = 32'(r_cfg.max_speed);
            default:                      prdata = '0;
        endcase
    end

endmodule

// File: hdl/hsms_step.sv
// ----------------------------------------------------------------------------
// hsms_step
// one tick of the phase sequencer: next phase, speed and heading
// ----------------------------------------------------------------------------
module hsms_step (
    input  hsms_pkg::t_cfg                                  i_cfg,
    input  hsms_pkg::t_state                                i_cur,
    input  logic signed [hsms_pkg::HEADING_IN_W-1:0]        i_desired,
    output hsms_pkg::t_state                                o_nxt
);

    logic signed [hsms_pkg::HEADING_IN_W-1:0] w_d_des;
    logic signed [hsms_pkg::HEADING_IN_W-1:0] w_d_goal;
    logic [hsms_pkg::ANGLE_W-1:0]             w_abs_des;
    logic                                     w_need_turn;
    logic [hsms_pkg::SPEED_W:0]               w_sum;
    logic [hsms_pkg::HEADING_W-1:0]           w_step;

    always_comb begin
        w_d_des   = hsms_pkg::wrap_angle(15'(i_desired) - 15'(i_cur.heading_now));
        w_d_goal  = hsms_pkg::wrap_angle(15'(i_cur.heading_goal) - 15'(i_cur.heading_now));
        w_abs_des = hsms_pkg::abs_angle(w_d_des);
        w_need_turn = w_abs_des > i_cfg.turn_threshold;
        w_sum     = {1'b0, i_cur.speed} + {1'b0, i_cfg.accel_step};
        w_step    = 14'(i_cfg.turn_step);

        o_nxt = i_cur;
        case (i_cur.phase)
            hsms_pkg::PH_ACCEL: begin
                if (w_need_turn) begin
                    o_nxt.phase = hsms_pkg::PH_DECEL;
                end else if (w_sum >= {1'b0, i_cfg.max_speed}) begin
                    o_nxt.speed = i_cfg.max_speed;
                    o_nxt.phase = hsms_pkg::PH_MOVING;
                end else begin
                    o_nxt.speed = w_sum[hsms_pkg::SPEED_W-1:0];
                end
            end
            hsms_pkg::PH_MOVING: begin
                if (w_need_turn) begin
                    o_nxt.phase = hsms_pkg::PH_DECEL;
                end
            end
            hsms_pkg::PH_TURNING: begin
                if (i_cur.turn_left <= i_cfg.turn_step) begin
                    o_nxt.heading_now = 14'(i_cur.heading_goal);
                    o_nxt.turn_left   = '0;
                    o_nxt.phase       = hsms_pkg::PH_ACCEL;
                end else begin
                    if (w_d_goal > 0) begin
                        o_nxt.heading_now = i_cur.heading_now + w_step;
                    end else begin
                        o_nxt.heading_now = i_cur.heading_now - w_step;
                    end
                    o_nxt.turn_left = i_cur.turn_left - i_cfg.turn_step;
                end
            end
            hsms_pkg::PH_DECEL: begin
                if (i_cur.speed <= i_cfg.accel_step) begin
                    o_nxt.speed = '0;
                    o_nxt.phase = hsms_pkg::PH_STOPPED;
                end else begin
                    o_nxt.speed = i_cur.speed - i_cfg.accel_step;
                end
            end
            default: begin
                // stopped, and unused codes
                if (w_need_turn) begin
                    o_nxt.turn_left    = w_abs_des;
                    o_nxt.heading_goal = i_desired;
                    o_nxt.phase        = hsms_pkg::PH_TURNING;
                end else begin
                    o_nxt.heading_now = 14'(i_desired);
                    o_nxt.phase       = hsms_pkg::PH_ACCEL;
                end
            end
        endcase
    end

endmodule

// File: tb/hsms_tb_pkg.sv
// ----------------------------------------------------------------------------
// hsms_tb_pkg
// Scoreboard for the motion sequencer bench. It tracks the sequencer phase,
// speed and heading tick by tick from the input beats, keeps the expected
// result beats in order and compares each output beat field by field.
// ----------------------------------------------------------------------------
package hsms_tb_pkg;

    class motion_tracker;

        typedef struct {
            hsms_pkg::t_phase                      phase;
            logic [hsms_pkg::SPEED_W-1:0]          speed;
            logic signed [hsms_pkg::HEADING_W-1:0] heading;
        } t_move;

        int     threshold;
        int     step;
        int     accel;
        int     top_speed;

        hsms_pkg::t_phase phase;
        int     heading_now;
        int     heading_goal;
        int     turn_left;
        int     speed;

        t_move  expected_moves[$];
        int     fails;

        function new();
            threshold    = int'(hsms_pkg::TURN_THRESHOLD_RST);
            step         = int'(hsms_pkg::TURN_STEP_RST);
            accel        = int'(hsms_pkg::ACCEL_STEP_RST);
            top_speed    = int'(hsms_pkg::MAX_SPEED_RST);
            phase        = hsms_pkg::PH_STOPPED;
            heading_now  = 0;
            heading_goal = 0;
            turn_left    = 0;
            speed        = 0;
            fails        = 0;
        endfunction

        function void set_reg(hsms_pkg::t_reg_idx idx, logic [31:0] value);
            case (idx)
                hsms_pkg::REG_TURN_THRESHOLD:
                    threshold = int'(value[hsms_pkg::ANGLE_W-1:0]);
                hsms_pkg::REG_TURN_STEP:
                    step      = int'(value[hsms_pkg::ANGLE_W-1:0]);
                hsms_pkg::REG_ACCEL_STEP:
                    accel     = int'(value[hsms_pkg::SPEED_W-1:0]);
                hsms_pkg::REG_MAX_SPEED:
                    top_speed = int'(value[hsms_pkg::SPEED_W-1:0]);
                default: ;
            endcase
        endfunction

        // fold a heading difference into plus or minus half a turn
        function int fold_angle(int a);
            while (a > int'(hsms_pkg::HALF_TURN)) a -= int'(hsms_pkg::FULL_TURN);
            while (a < -int'(hsms_pkg::HALF_TURN)) a += int'(hsms_pkg::FULL_TURN);
            return a;
        endfunction

        function int magnitude(int a);
            return (a < 0) ? -a : a;
        endfunction

        function bit off_course(int desired);
            return magnitude(fold_angle(desired - heading_now)) > threshold;
        endfunction

        function void note_heading(logic signed [hsms_pkg::HEADING_IN_W-1:0] h);
            int    desired;
            int    err;
            int    sum;
            t_move m;
            desired = h;
            case (phase)
                hsms_pkg::PH_ACCEL: begin
                    if (off_course(desired)) begin
                        phase = hsms_pkg::PH_DECEL;
                    end else begin
                        sum = speed + accel;
                        if (sum >= top_speed) begin
                            speed = top_speed;
                            phase = hsms_pkg::PH_MOVING;
                        end else begin
                            speed = sum;
                        end
                    end
                end
                hsms_pkg::PH_MOVING: begin
                    if (off_course(desired)) begin
                        phase = hsms_pkg::PH_DECEL;
                    end
                end
                hsms_pkg::PH_TURNING: begin
                    if (turn_left <= step) begin
                        heading_now = heading_goal;
                        turn_left   = 0;
                        phase       = hsms_pkg::PH_ACCEL;
                    end else begin
                        err = fold_angle(heading_goal - heading_now);
                        heading_now += (err > 0) ? step : -step;
                        turn_left   -= step;
                    end
                end
                hsms_pkg::PH_DECEL: begin
                    if (speed <= accel) begin
                        speed = 0;
                        phase = hsms_pkg::PH_STOPPED;
                    end else begin
                        speed -= accel;
                    end
                end
                default: begin
                    err = fold_angle(desired - heading_now);
                    if (magnitude(err) > threshold) begin
                        turn_left    = magnitude(err) & 'hFFF;
                        heading_goal = desired;
                        phase        = hsms_pkg::PH_TURNING;
                    end else begin
                        heading_now = desired;
                        phase       = hsms_pkg::PH_ACCEL;
                    end
                end
            endcase
            m.phase   = phase;
            m.speed   = speed[hsms_pkg::SPEED_W-1:0];
            m.heading = heading_now[hsms_pkg::HEADING_W-1:0];
            expected_moves.push_back(m);
        endfunction

        function void check_beat(logic [2:0] ph, logic [hsms_pkg::SPEED_W-1:0] sp,
                                 logic signed [hsms_pkg::HEADING_W-1:0] hd);
            t_move m;
            if (expected_moves.size() == 0) begin
                fails++;
                $error("result beat with nothing expected");
                return;
            end
            m = expected_moves.pop_front();
            if (ph !== m.phase) begin
                fails++;
                $error("phase_out: expected %0d, actual %0d", m.phase, ph);
            end
            if (sp !== m.speed) begin
                fails++;
                $error("speed_out: expected %0d, actual %0d", m.speed, sp);
            end
            if (hd !== m.heading) begin
                fails++;
                $error("heading_out: expected %0d, actual %0d", m.heading, hd);
            end
        endfunction

        function int pending();
            return expected_moves.size();
        endfunction

    endclass

endpackage

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Bench for the heading and speed motion sequencer. A directed run walks the
// phases, half turns, out of range headings and zero step settings, then
// random heading streams run under several register settings with idling on
// both sides, a long receiver hold-off and a sender pause.
// ----------------------------------------------------------------------------
module tb;

    localparam int QUIET_LIMIT  = 3000;
    localparam int LONG_HOLD    = 400;
    localparam int SEGMENTS     = 9;
    localparam int SEG_ITEMS    = 189;
    localparam int JITTER       = 150;

    logic                                     i_clk;
    logic                                     i_rst_n           = 1'b0;
    logic                                     psel              = 1'b0;
    logic                                     penable           = 1'b0;
    logic                                     pwrite            = 1'b0;
    logic [hsms_pkg::CFG_ADDR_W-1:0]          paddr             = '0;
    logic [hsms_pkg::CFG_DATA_W-1:0]          pwdata            = '0;
    logic [hsms_pkg::CFG_DATA_W-1:0]          prdata;
    logic                                     pready;
    logic                                     i_valid           = 1'b0;
    logic                                     o_stall;
    logic signed [hsms_pkg::HEADING_IN_W-1:0] i_desired_heading = '0;
    logic                                     o_valid;
    logic                                     i_stall           = 1'b1;
    logic [2:0]                               o_phase_out;
    logic [hsms_pkg::SPEED_W-1:0]             o_speed_out;
    logic signed [hsms_pkg::HEADING_W-1:0]    o_heading_out;

    logic                                     long_hold         = 1'b0;
    int                                       holds_requested   = 0;
    int                                       send_idle         = 0;
    int                                       recv_idle         = 0;
    int                                       course            = 0;

    hsms_tb_pkg::motion_tracker               tracker;

    heading_speed_motion_sequencer_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_desired_heading (i_desired_heading),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_phase_out       (o_phase_out),
        .o_speed_out       (o_speed_out),
        .o_heading_out     (o_heading_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_stall <= long_hold || ($urandom_range(99) < recv_idle);
    end

    initial begin : receiver_hold_off
        int served;
        served = 0;
        forever begin
            @(posedge i_clk);
            if (holds_requested != served) begin
                served++;
                long_hold <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            tracker.check_beat(o_phase_out, o_speed_out, o_heading_out);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || psel || !i_rst_n) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Verification failed");
        $finish;
    end

    task automatic send_heading(input logic signed [hsms_pkg::HEADING_IN_W-1:0] h);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_desired_heading <= h;
        do @(posedge i_clk); while (o_stall);
        tracker.note_heading(h);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    // back to back writes keep psel high, the bus is released by the caller
    task automatic write_reg(input hsms_pkg::t_reg_idx idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        tracker.set_reg(idx, value);
    endtask

    task automatic set_config(input int th, input int st, input int ac, input int mx);
        drain_results();
        write_reg(hsms_pkg::REG_TURN_THRESHOLD, th);
        write_reg(hsms_pkg::REG_TURN_STEP, st);
        write_reg(hsms_pkg::REG_ACCEL_STEP, ac);
        write_reg(hsms_pkg::REG_MAX_SPEED, mx);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // mostly small wander around a course, sometimes a new course, rarely anything
    function automatic logic signed [hsms_pkg::HEADING_IN_W-1:0] pick_heading();
        int          r;
        int          v;
        logic [31:0] raw;
        r = $urandom_range(99);
        if (r < 3) begin
            raw = $urandom;
            return raw[hsms_pkg::HEADING_IN_W-1:0];
        end
        if (r < 15) begin
            course = int'($urandom_range(5760)) - 2880;
            return course[hsms_pkg::HEADING_IN_W-1:0];
        end
        v = course + int'($urandom_range(2 * JITTER)) - JITTER;
        return v[hsms_pkg::HEADING_IN_W-1:0];
    endfunction

    initial begin : stimulus
        int mode;
        tracker = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: ramp, brake, out of range headings, then a turn
        send_heading(0);
        send_heading(80);
        send_heading(81);
        send_heading(4095);
        send_heading(4095);
        send_heading(-4096);
        send_heading(2880);

        // zero turn step holds the pending turn
        set_config(0, 0, 0, 0);
        send_heading(-2880);
        send_heading(2880);
        send_heading(0);
        send_heading(-1);

        // zero accel and zero cruise speed, exact half turn
        set_config(0, 2880, 0, 0);
        send_heading(4095);
        send_heading(4095);
        send_heading(-2880);
        send_heading(-2880);
        send_heading(2880);
        send_heading(2880);
        send_heading(0);
        send_heading(0);
        send_heading(0);
        send_heading(0);

        // half turn threshold, unit turn step, top of accel step and max speed ranges
        set_config(2880, 1, 65535, 65535);
        send_heading(0);
        send_heading(-4096);
        send_heading(4095);

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (seg)
                0:       set_config(80, 400, 1024, 8192);
                1:       set_config(0, 2880, 65535, 65535);
                2:       set_config(2880, 1, 1, 0);
                3:       set_config(0, 2880, 1, 300);
                4:       set_config(200, 700, 3000, 20000);
                5:       set_config(40, 2000, 30000, 65535);
                default: set_config($urandom_range(2880), $urandom_range(2880, 300),
                                    $urandom_range(65535, 500), $urandom_range(65535));
            endcase
            mode = seg * 3 / SEGMENTS;
            recv_idle = (mode == 0) ? 61 : (mode == 1) ? 36 : 0;
            for (int n = 0; n < SEG_ITEMS; n++) begin
                if (seg == 4 && n == 50) begin
                    holds_requested++;
                end
                if (seg == 2 && n == 100) begin
                    drain_results();
                end
                // keep offering while the receiver holds off
                if (seg == 4 && n >= 50 && n < 90) begin
                    send_idle = 0;
                end else begin
                    send_idle = (mode == 0) ? 36 : (mode == 1) ? 61 : 0;
                end
                send_heading(pick_heading());
            end
        end

        drain_results();
        repeat (4) @(posedge i_clk);
        if (tracker.fails == 0 && tracker.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/hsms_pkg.sv
hdl/hsms_cfg.sv
hdl/hsms_step.sv
hdl/heading_speed_motion_sequencer_unit.sv
tb/hsms_tb_pkg.sv
tb/tb.sv
